### src/bfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener package
// Widths, the job word that passes from the set-up side to the point
// generator, and the output rounding function.
// ----------------------------------------------------------------------------
package bfl_pkg;

  localparam int MAX_POINTS = 64;
  localparam int NB    = $clog2(MAX_POINTS);   // segment count width
  localparam int CW    = 24;                   // coordinate width
  localparam int AW    = 51;                   // area, signed and magnitude
  localparam int KW    = 29;                   // polynomial coefficients
  localparam int NUMW  = 44;                   // difference numerators
  localparam int DW    = 3 * NB;               // n cubed
  localparam int DVW   = NUMW + 24;            // scaled dividend magnitude
  localparam int ACCW  = 64;                   // Q.32 accumulators
  localparam int DIV_CYC = DVW / 2;            // two quotient bits a cycle
  localparam int DCW   = $clog2(DIV_CYC + 1);

  typedef struct packed {
    logic signed [CW-1:0]   x0;
    logic signed [CW-1:0]   y0;
    logic signed [CW-1:0]   x3;
    logic signed [CW-1:0]   y3;
    logic [NB-1:0]          n;
    logic signed [ACCW-1:0] dx1;
    logic signed [ACCW-1:0] dx2;
    logic signed [ACCW-1:0] dx3;
    logic signed [ACCW-1:0] dy1;
    logic signed [ACCW-1:0] dy2;
    logic signed [ACCW-1:0] dy3;
  } job_t;

  // Q.32 to Q16.8, rounding half up, saturating to the coordinate range.
  function automatic logic signed [CW-1:0] round_q8(input logic signed [ACCW-1:0] v);
    logic signed [ACCW:0]     s;
    logic signed [ACCW-24:0]  sh;
    logic signed [CW-1:0]     r;
    s  = {v[ACCW-1], v} + (ACCW+1)'(1 << 23);
    sh = (ACCW-23)'(s >>> 24);
    if (sh > (ACCW-23)'((1 << (CW-1)) - 1)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (sh < -(ACCW-23)'(1 << (CW-1))) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = sh[CW-1:0];
    end
    return r;
  endfunction

endpackage

### src/cubic_bezier_flattener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener
// A curve of four Q16.8 control points goes in; its vertices, from the start
// point to the flagged end point, come out one word at a time.
// ----------------------------------------------------------------------------
// The set-up side takes one curve at a time: the two cross products on a
// shared multiplier, the segment count search, the coefficients and the six
// differences, which are divided in parallel two quotient bits a cycle. A
// degenerate curve skips the last two parts. Jobs then wait in a two-entry
// queue for the generator, which loads a job while idle and then emits its
// n+1 vertices (two for a degenerate curve) as the result side pops them. A
// new curve is accepted as soon as the previous one has reached the queue.
module cubic_bezier_flattener (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic signed [bfl_pkg::CW-1:0]   in_start_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_start_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl1_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl1_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl2_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl2_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_end_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_end_y,
  input  logic                            pop,
  output logic                            empty,
  output logic signed [bfl_pkg::CW-1:0]   out_point_x,
  output logic signed [bfl_pkg::CW-1:0]   out_point_y,
  output logic                            out_last_point
);

  logic          job_push, job_full, job_pop, job_empty;
  bfl_pkg::job_t job_in, job_out;

  bfl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_ctrl1_x (in_ctrl1_x),
    .in_ctrl1_y (in_ctrl1_y),
    .in_ctrl2_x (in_ctrl2_x),
    .in_ctrl2_y (in_ctrl2_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .job_push   (job_push),
    .job_full   (job_full),
    .job        (job_in)
  );

  bfl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (job_push),
    .wdata  (job_in),
    .qfull  (job_full),
    .rd     (job_pop),
    .rdata  (job_out),
    .qempty (job_empty)
  );

  bfl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .job            (job_out),
    .pop            (pop),
    .empty          (empty),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

endmodule

### src/bfl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener divider
// Floor of a signed numerator times 2^24 over a positive divisor, two
// restoring steps a cycle.
// ----------------------------------------------------------------------------
module bfl_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [bfl_pkg::NUMW-1:0]   num,
  input  logic [bfl_pkg::DW-1:0]            den,
  output logic                              busy,
  output logic signed [bfl_pkg::ACCW-1:0]   quo
);

  logic                         busy_r;
  logic [bfl_pkg::DCW-1:0]      cnt_r;
  logic                         neg_r;
  logic [bfl_pkg::DVW-1:0]      q_r, q_nxt;
  logic [bfl_pkg::DW-1:0]       rem_r, rem_nxt;
  logic [bfl_pkg::DW-1:0]       den_r;
  logic [bfl_pkg::NUMW-1:0]     mag;
  logic [bfl_pkg::DW:0]         part;
  logic [bfl_pkg::DVW-1:0]      qneg;

  assign mag = num[bfl_pkg::NUMW-1] ? bfl_pkg::NUMW'(-num) : bfl_pkg::NUMW'(num);

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    part    = '0;
    for (int i = 0; i < 2; i++) begin
      part  = {rem_nxt, q_nxt[bfl_pkg::DVW-1]};
      q_nxt = {q_nxt[bfl_pkg::DVW-2:0], 1'b0};
      if (part >= {1'b0, den_r}) begin
        part     = part - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = part[bfl_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == bfl_pkg::DCW'(bfl_pkg::DIV_CYC - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= {mag, 24'b0};
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[bfl_pkg::NUMW-1];
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // A negative quotient rounds towards minus infinity when a remainder is left.
  assign qneg = (rem_r != '0) ? ~q_r : ~q_r + 1'b1;
  assign quo  = neg_r ? $signed(qneg[bfl_pkg::ACCW-1:0]) : $signed(q_r[bfl_pkg::ACCW-1:0]);
  assign busy = busy_r;

endmodule

### src/bfl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener set-up
// Takes a curve, finds its segment count and the forward differences, and
// hands the result on as one job word.
// ----------------------------------------------------------------------------
module bfl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic signed [bfl_pkg::CW-1:0]   in_start_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_start_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl1_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl1_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl2_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_ctrl2_y,
  input  logic signed [bfl_pkg::CW-1:0]   in_end_x,
  input  logic signed [bfl_pkg::CW-1:0]   in_end_y,
  output logic                            job_push,
  input  logic                            job_full,
  output bfl_pkg::job_t                   job
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_C1   = 3'd3;
  localparam logic [2:0] S_C2   = 3'd4;
  localparam logic [2:0] S_C3   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_PUSH = 3'd7;

  localparam int NB = bfl_pkg::NB;
  localparam int KW = bfl_pkg::KW;

  logic [2:0] st_r;
  logic [2:0] cnt_r;
  logic signed [bfl_pkg::CW-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;

  logic signed [bfl_pkg::CW:0]     ma, mb;
  logic signed [2*bfl_pkg::CW+1:0] prod, prod_r, s_r;
  logic signed [bfl_pkg::AW-1:0]   dif;
  logic [bfl_pkg::AW-1:0]          dabs, aa_r, amax_r;

  logic [NB-1:0]   n_r, mask_r, trial, n_try, n_cl;
  logic [2*NB-1:0] sq, n2_r;
  logic [bfl_pkg::DW-1:0] n3_r;

  logic signed [KW-1:0] xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;
  logic signed [KW+NB:0]   xbn_r, ybn_r;
  logic signed [KW+2*NB:0] xcn2_r, ycn2_r;
  logic signed [bfl_pkg::NUMW-1:0] xa_e, ya_e, xbn_e, ybn_e;
  logic signed [bfl_pkg::NUMW-1:0] num [6];
  logic signed [bfl_pkg::ACCW-1:0] quo [6];
  logic [5:0] dbusy;
  logic       dstart;

  function automatic logic signed [bfl_pkg::CW:0] sx(input logic signed [bfl_pkg::CW-1:0] v);
    return {v[bfl_pkg::CW-1], v};
  endfunction

  function automatic logic signed [KW-1:0] kx(input logic signed [bfl_pkg::CW-1:0] v);
    return KW'(v);
  endfunction

  // The two cross products share one multiplier.
  always_comb begin
    case (cnt_r)
      3'd0: begin
        ma = sx(x0_r) - sx(x2_r);
        mb = sx(y3_r) - sx(y1_r);
      end
      3'd1: begin
        ma = sx(y0_r) - sx(y2_r);
        mb = sx(x3_r) - sx(x1_r);
      end
      3'd2: begin
        ma = sx(x0_r) - sx(x3_r);
        mb = sx(y2_r) - sx(y1_r);
      end
      default: begin
        ma = sx(y0_r) - sx(y3_r);
        mb = sx(x2_r) - sx(x1_r);
      end
    endcase
  end

  assign prod = ma * mb;
  assign dif  = {s_r[2*bfl_pkg::CW+1], s_r} - {prod_r[2*bfl_pkg::CW+1], prod_r};
  assign dabs = dif[bfl_pkg::AW-1] ? bfl_pkg::AW'(-dif) : bfl_pkg::AW'(dif);

  // Segment count: the largest n whose square fits under the area over 2^20.
  assign trial = n_r | mask_r;
  assign sq    = trial * trial;
  assign n_try = ({{(bfl_pkg::AW-2*NB){1'b0}}, sq} <= (amax_r >> 20)) ? trial : n_r;
  assign n_cl  = (n_try > NB'(bfl_pkg::MAX_POINTS - 1)) ? NB'(bfl_pkg::MAX_POINTS - 1) : n_try;

  assign xa_e  = bfl_pkg::NUMW'(xa_r);
  assign ya_e  = bfl_pkg::NUMW'(ya_r);
  assign xbn_e = bfl_pkg::NUMW'(xbn_r);
  assign ybn_e = bfl_pkg::NUMW'(ybn_r);

  assign num[0] = xa_e + xbn_e + bfl_pkg::NUMW'(xcn2_r);
  assign num[1] = (xa_e <<< 2) + (xa_e <<< 1) + (xbn_e <<< 1);
  assign num[2] = (xa_e <<< 2) + (xa_e <<< 1);
  assign num[3] = ya_e + ybn_e + bfl_pkg::NUMW'(ycn2_r);
  assign num[4] = (ya_e <<< 2) + (ya_e <<< 1) + (ybn_e <<< 1);
  assign num[5] = (ya_e <<< 2) + (ya_e <<< 1);

  assign dstart = (st_r == S_C3);

  for (genvar g = 0; g < 6; g++) begin : g_div
    bfl_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (dstart),
      .num   (num[g]),
      .den   (n3_r),
      .busy  (dbusy[g]),
      .quo   (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (push) begin
            st_r  <= S_MUL;
            cnt_r <= '0;
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 3'd4) begin
            st_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (mask_r[0]) begin
            st_r <= (n_cl > NB'(1)) ? S_C1 : S_PUSH;
          end
        end
        S_C1:   st_r <= S_C2;
        S_C2:   st_r <= S_C3;
        S_C3:   st_r <= S_DIV;
        S_DIV: begin
          if (dbusy == '0) begin
            st_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!job_full) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && push) begin
      x0_r <= in_start_x;
      y0_r <= in_start_y;
      x1_r <= in_ctrl1_x;
      y1_r <= in_ctrl1_y;
      x2_r <= in_ctrl2_x;
      y2_r <= in_ctrl2_y;
      x3_r <= in_end_x;
      y3_r <= in_end_y;
    end
    if (st_r == S_MUL) begin
      prod_r <= prod;
      if (cnt_r == 3'd1 || cnt_r == 3'd3) begin
        s_r <= prod_r;
      end
      if (cnt_r == 3'd2) begin
        aa_r <= dabs;
      end
      if (cnt_r == 3'd4) begin
        amax_r <= (dabs > aa_r) ? dabs : aa_r;
        n_r    <= '0;
        mask_r <= {1'b1, {(NB-1){1'b0}}};
      end
    end
    if (st_r == S_SRCH) begin
      mask_r <= mask_r >> 1;
      n_r    <= mask_r[0] ? n_cl : n_try;
    end
    if (st_r == S_C1) begin
      xa_r <= kx(x3_r) - KW'(3) * kx(x2_r) + KW'(3) * kx(x1_r) - kx(x0_r);
      xb_r <= KW'(3) * (kx(x2_r) - KW'(2) * kx(x1_r) + kx(x0_r));
      xc_r <= KW'(3) * (kx(x1_r) - kx(x0_r));
      ya_r <= kx(y3_r) - KW'(3) * kx(y2_r) + KW'(3) * kx(y1_r) - kx(y0_r);
      yb_r <= KW'(3) * (kx(y2_r) - KW'(2) * kx(y1_r) + kx(y0_r));
      yc_r <= KW'(3) * (kx(y1_r) - kx(y0_r));
      n2_r <= n_r * n_r;
    end
    if (st_r == S_C2) begin
      n3_r   <= n2_r * n_r;
      xbn_r  <= xb_r * $signed({1'b0, n_r});
      ybn_r  <= yb_r * $signed({1'b0, n_r});
      xcn2_r <= xc_r * $signed({1'b0, n2_r});
      ycn2_r <= yc_r * $signed({1'b0, n2_r});
    end
  end

  assign full     = (st_r != S_IDLE);
  assign job_push = (st_r == S_PUSH) && !job_full;

  always_comb begin
    job.x0  = x0_r;
    job.y0  = y0_r;
    job.x3  = x3_r;
    job.y3  = y3_r;
    job.n   = n_r;
    job.dx1 = quo[0];
    job.dx2 = quo[1];
    job.dx3 = quo[2];
    job.dy1 = quo[3];
    job.dy2 = quo[4];
    job.dy3 = quo[5];
  end

endmodule

### src/bfl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener job queue
// Two-entry queue of job words between the set-up side and the generator.
// ----------------------------------------------------------------------------
module bfl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  bfl_pkg::job_t   wdata,
  output logic            qfull,
  input  logic            rd,
  output bfl_pkg::job_t   rdata,
  output logic            qempty
);

  bfl_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata  = mem_r[rp_r];
  assign qfull  = (cnt_r == 2'd2);
  assign qempty = (cnt_r == 2'd0);

endmodule

### src/bfl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener point generator
// Steps the forward differences of one job and emits one vertex a cycle
// into the output register while it is empty or being popped.
// ----------------------------------------------------------------------------
module bfl_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_empty,
  output logic                            job_pop,
  input  bfl_pkg::job_t                   job,
  input  logic                            pop,
  output logic                            empty,
  output logic signed [bfl_pkg::CW-1:0]   out_point_x,
  output logic signed [bfl_pkg::CW-1:0]   out_point_y,
  output logic                            out_last_point
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_P0   = 2'd1;
  localparam logic [1:0] B_INT  = 2'd2;
  localparam logic [1:0] B_END  = 2'd3;

  logic [1:0]              st_r;
  logic [bfl_pkg::NB-1:0]  cnt_r;
  bfl_pkg::job_t           j_r;
  logic signed [bfl_pkg::ACCW-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  logic                    ov_r, slot_ok;
  logic signed [bfl_pkg::CW-1:0] ox_r, oy_r;
  logic                    ol_r;

  assign slot_ok = !ov_r || pop;
  assign job_pop = (st_r == B_IDLE) && !job_empty;
  assign ax_nxt  = ax_r + j_r.dx1;
  assign ay_nxt  = ay_r + j_r.dy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (pop) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (!job_empty) begin
            st_r <= B_P0;
          end
        end
        B_P0: begin
          if (slot_ok) begin
            ov_r <= 1'b1;
            st_r <= (j_r.n > bfl_pkg::NB'(1)) ? B_INT : B_END;
          end
        end
        B_INT: begin
          if (slot_ok) begin
            ov_r <= 1'b1;
            if (cnt_r == bfl_pkg::NB'(1)) begin
              st_r <= B_END;
            end
          end
        end
        B_END: begin
          if (slot_ok) begin
            ov_r <= 1'b1;
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        j_r   <= job;
        ax_r  <= bfl_pkg::ACCW'(job.x0) <<< 24;
        ay_r  <= bfl_pkg::ACCW'(job.y0) <<< 24;
        cnt_r <= job.n - 1'b1;
      end
      B_P0: begin
        if (slot_ok) begin
          ox_r <= j_r.x0;
          oy_r <= j_r.y0;
          ol_r <= 1'b0;
        end
      end
      B_INT: begin
        if (slot_ok) begin
          ax_r    <= ax_nxt;
          ay_r    <= ay_nxt;
          j_r.dx1 <= j_r.dx1 + j_r.dx2;
          j_r.dx2 <= j_r.dx2 + j_r.dx3;
          j_r.dy1 <= j_r.dy1 + j_r.dy2;
          j_r.dy2 <= j_r.dy2 + j_r.dy3;
          cnt_r   <= cnt_r - 1'b1;
          ox_r    <= bfl_pkg::round_q8(ax_nxt);
          oy_r    <= bfl_pkg::round_q8(ay_nxt);
          ol_r    <= 1'b0;
        end
      end
      default: begin
        if (slot_ok) begin
          ox_r <= j_r.x3;
          oy_r <= j_r.y3;
          ol_r <= 1'b1;
        end
      end
    endcase
  end

  assign empty          = !ov_r;
  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_last_point = ol_r;

endmodule

### src/bfl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier flattener port checker
// Watches the top-level ports for slips in reset and hand-shake behaviour.
// ----------------------------------------------------------------------------
module bfl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            push,
  input logic                            full,
  input logic                            pop,
  input logic                            empty,
  input logic signed [bfl_pkg::CW-1:0]   out_point_x,
  input logic signed [bfl_pkg::CW-1:0]   out_point_y,
  input logic                            out_last_point
);

  // A waiting word may not change or vanish until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_point_x) && $stable(out_point_y)
                       && $stable(out_last_point))
    else $error("waiting word changed before pop");

  // Nothing can be waiting straight after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("output not empty after reset");

  // The set-up side holds one curve at a time, so an accepted word closes it.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |=> full)
    else $error("input open right after an accepted word");

endmodule

bind cubic_bezier_flattener bfl_chk u_bfl_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .pop            (pop),
  .empty          (empty),
  .out_point_x    (out_point_x),
  .out_point_y    (out_point_y),
  .out_last_point (out_last_point)
);
